// ===== rtl/sitr_pkg.sv =====
// ----------------------------------------------------------------------------
// sitr_pkg: shared types, constants and functions
// Constants, the status struct and the small arithmetic helpers used by the
// radix text unit and its symbol table checker.
// ----------------------------------------------------------------------------
package sitr_pkg;

    localparam int MAX_BASE_DEF = 16;

    // Symbol table: sixteen byte slots split over two 64-bit registers.
    localparam int SYM_SLOTS   = 16;
    localparam int SYM_IDX_W   = 4;
    localparam int RADIX_W     = 5;

    // Magnitude is processed one nibble per cycle, most significant first.
    localparam int MAG_W       = 32;
    localparam int NIB_W       = 4;
    localparam int NIB_COUNT   = 8;
    localparam int PTR_W       = 3;
    localparam int LEN_W       = 4;

    // A 32-bit magnitude never has more than 32 digits in radix two.
    localparam int DIGIT_SLOTS = 32;
    localparam int COUNT_W     = 6;

    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 64;

    localparam logic [7:0] SYM_PLUS  = 8'd43;
    localparam logic [7:0] SYM_MINUS = 8'd45;
    localparam logic [7:0] SYM_NUL   = 8'd0;

    typedef logic [7:0] sym_t;

    typedef enum logic [1:0] {
        REG_SYM_LO   = 2'd0,
        REG_SYM_HI   = 2'd1,
        REG_BASE_LEN = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIVIDE,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic running;
        logic ok;
    } chk_status_t;

    // One nibble of long division by the radix. The incoming remainder is
    // below the radix, so the quotient nibble and the new remainder each fit
    // in four bits. Returns {quotient, remainder}.
    function automatic logic [7:0] div_step(
        input logic [3:0] rem,
        input logic [3:0] nib,
        input logic [4:0] radix
    );
        logic [4:0] acc;
        logic [3:0] q;
        acc = {1'b0, rem};
        q   = '0;
        for (int b = 3; b >= 0; b--)
        begin
            acc = {acc[3:0], nib[b]};
            if (acc >= radix)
            begin
                acc  = acc - radix;
                q[b] = 1'b1;
            end
        end
        return {q, acc[3:0]};
    endfunction

    // Number of significant nibbles, at least one so that zero still yields
    // a single digit.
    function automatic logic [3:0] sig_nibbles(input logic [31:0] mag);
        logic [3:0] n;
        n = 4'd1;
        for (int k = 0; k < 8; k++)
        begin
            if (mag[4*k +: 4] != 4'd0)
            begin
                n = 4'(k + 1);
            end
        end
        return n;
    endfunction

endpackage

// ===== rtl/sitr_check.sv =====
// ----------------------------------------------------------------------------
// sitr_check: symbol table checker
// Walks the symbol slots one per cycle after every register write and decides
// whether the table forms a usable radix: length in range, no forbidden
// symbol, no symbol used twice.
// ----------------------------------------------------------------------------
module sitr_check #(
    parameter int MAX_BASE = sitr_pkg::MAX_BASE_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   restart,
    input  sitr_pkg::sym_t                         syms [sitr_pkg::SYM_SLOTS],
    input  logic [sitr_pkg::RADIX_W-1:0]           base_length,
    output sitr_pkg::chk_status_t                  status
);

    localparam int IW  = $clog2(MAX_BASE);
    localparam int SIW = sitr_pkg::SYM_IDX_W;
    localparam int RW  = sitr_pkg::RADIX_W;

    logic [IW-1:0] idx_reg, idx_next;
    logic          running_reg, running_next;
    logic          ok_reg, ok_next;

    sitr_pkg::sym_t cur;
    logic           in_use;
    logic           range_bad;
    logic           forbidden;
    logic           dup_hit;
    logic           fault;
    logic           last;

    always_comb
    begin
        cur       = syms[SIW'(idx_reg)];
        in_use    = RW'(idx_reg) < base_length;
        range_bad = (base_length < RW'(2)) || (base_length > RW'(MAX_BASE));
        forbidden = (cur == sitr_pkg::SYM_PLUS) || (cur == sitr_pkg::SYM_MINUS) ||
                    (cur == sitr_pkg::SYM_NUL);
        // Compare the current symbol with every later symbol in use.
        dup_hit = 1'b0;
        for (int j = 0; j < MAX_BASE; j++)
        begin
            if ((IW'(j) > idx_reg) && (RW'(j) < base_length) && (syms[j] == cur))
            begin
                dup_hit = 1'b1;
            end
        end
        fault = range_bad || (in_use && (forbidden || dup_hit));
        last  = (idx_reg == IW'(MAX_BASE - 1));
    end

    always_comb
    begin
        idx_next     = idx_reg;
        running_next = running_reg;
        ok_next      = ok_reg;
        if (restart)
        begin
            idx_next     = '0;
            running_next = 1'b1;
            ok_next      = 1'b1;
        end
        else if (running_reg)
        begin
            if (fault)
            begin
                ok_next = 1'b0;
            end
            if (last)
            begin
                running_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            running_reg <= 1'b0;
            ok_reg      <= 1'b0;
        end
        else
        begin
            idx_reg     <= idx_next;
            running_reg <= running_next;
            ok_reg      <= ok_next;
        end
    end

    assign status.running = running_reg;
    assign status.ok      = ok_reg;

endmodule

// ===== rtl/signed_integer_to_radix_text_unit.sv =====
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text_unit: signed integer to radix text
// Prints a signed 32-bit value as text in a radix defined by a table of
// symbol bytes, one character per result strobe.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its characters then
// appear one per cycle on character with strobe high, a leading minus sign
// for negative values first, then the digits most significant first, with
// last_char set on the final one; the receiver cannot stall them, and a
// request made while the symbol table is invalid produces no characters.
// The magnitude is divided by the radix one nibble per cycle, and each pass
// covers only the significant nibbles of the current quotient. After every
// register write the table check keeps busy high while it walks the symbol
// slots.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text_unit #(
    parameter int MAX_BASE = sitr_pkg::MAX_BASE_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sitr_pkg::ADDR_W-1:0]      paddr,
    input  logic [sitr_pkg::DATA_W-1:0]      pwdata,
    output logic [sitr_pkg::DATA_W-1:0]      prdata,
    output logic                             pready,
    // Request side
    input  logic                             start,
    input  logic signed [31:0]               value,
    output logic                             busy,
    // Result side
    output logic                             strobe,
    output logic [7:0]                       character,
    output logic                             last_char
);

    localparam int DW    = $clog2(MAX_BASE);
    localparam int SIW   = sitr_pkg::SYM_IDX_W;
    localparam int NW    = sitr_pkg::NIB_W;
    localparam int PW    = sitr_pkg::PTR_W;
    localparam int LW    = sitr_pkg::LEN_W;
    localparam int CW    = sitr_pkg::COUNT_W;
    localparam int MW    = sitr_pkg::MAG_W;
    localparam int SLOTS = sitr_pkg::DIGIT_SLOTS;

    // Configuration registers
    logic [63:0]                  sym_lo_reg;
    logic [63:0]                  sym_hi_reg;
    logic [sitr_pkg::RADIX_W-1:0] base_len_reg;

    sitr_pkg::sym_t        syms [sitr_pkg::SYM_SLOTS];
    sitr_pkg::chk_status_t chk;
    sitr_pkg::reg_idx_t    reg_sel;
    logic                  cfg_write;
    logic                  accept;

    // Control and datapath registers
    sitr_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    nd_reg, nd_next;
    logic [MW-1:0]    mag_reg, mag_next;
    logic             neg_reg, neg_next;
    logic [LW-1:0]    len_reg, len_next;
    logic [PW-1:0]    ptr_reg, ptr_next;
    logic [NW-1:0]    rem_reg, rem_next;
    logic             topz_reg, topz_next;
    logic [DW-1:0]    stack_reg  [SLOTS];
    logic [DW-1:0]    stack_next [SLOTS];

    logic [MW-1:0]    value_u;
    logic [LW-1:0]    load_len;
    logic [NW-1:0]    nib;
    logic [7:0]       step;
    logic [NW-1:0]    q;
    logic [NW-1:0]    r;
    logic             at_top;
    logic             top_zero;
    logic [LW-1:0]    len_new;
    logic             pass_end;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = sitr_pkg::reg_idx_t'(paddr[4:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_lo_reg   <= '0;
            sym_hi_reg   <= '0;
            base_len_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                sitr_pkg::REG_SYM_LO:   sym_lo_reg   <= pwdata;
                sitr_pkg::REG_SYM_HI:   sym_hi_reg   <= pwdata;
                sitr_pkg::REG_BASE_LEN: base_len_reg <= pwdata[sitr_pkg::RADIX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            sitr_pkg::REG_SYM_LO:   prdata = sym_lo_reg;
            sitr_pkg::REG_SYM_HI:   prdata = sym_hi_reg;
            sitr_pkg::REG_BASE_LEN: prdata = 64'(base_len_reg);
            default:                prdata = '0;
        endcase
    end

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            syms[k]     = sym_lo_reg[8*k +: 8];
            syms[k + 8] = sym_hi_reg[8*k +: 8];
        end
    end

    sitr_check #(
        .MAX_BASE    (MAX_BASE)
    ) u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .restart     (cfg_write),
        .syms        (syms),
        .base_length (base_len_reg),
        .status      (chk)
    );

    // ------------------------------------------------------------------
    // Request handshake
    // ------------------------------------------------------------------
    assign busy   = (state_reg != sitr_pkg::ST_IDLE) || chk.running;
    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // Nibble-serial division by the radix
    // ------------------------------------------------------------------
    assign value_u  = unsigned'(value);
    assign load_len = sitr_pkg::sig_nibbles(mag_reg);
    assign nib      = mag_reg[{ptr_reg, 2'b00} +: NW];
    assign step     = sitr_pkg::div_step(rem_reg, nib, base_len_reg);
    assign q        = step[7:4];
    assign r        = step[3:0];

    // The quotient loses at most one nibble per pass, since the top nibble
    // of the dividend is always nonzero.
    assign at_top   = (ptr_reg == PW'(len_reg - LW'(1)));
    assign top_zero = at_top ? (q == '0) : topz_reg;
    assign len_new  = top_zero ? (len_reg - LW'(1)) : len_reg;
    assign pass_end = (ptr_reg == '0);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sitr_pkg::ST_IDLE:
            begin
                if (accept && chk.ok)
                begin
                    state_next = sitr_pkg::ST_LOAD;
                end
            end
            sitr_pkg::ST_LOAD:
            begin
                state_next = sitr_pkg::ST_DIVIDE;
            end
            sitr_pkg::ST_DIVIDE:
            begin
                if (pass_end && (len_new == '0))
                begin
                    state_next = neg_reg ? sitr_pkg::ST_SIGN : sitr_pkg::ST_EMIT;
                end
            end
            sitr_pkg::ST_SIGN:
            begin
                state_next = sitr_pkg::ST_EMIT;
            end
            sitr_pkg::ST_EMIT:
            begin
                if (nd_reg == CW'(1))
                begin
                    state_next = sitr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sitr_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        nd_next    = nd_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        len_next   = len_reg;
        ptr_next   = ptr_reg;
        rem_next   = rem_reg;
        topz_next  = topz_reg;
        stack_next = stack_reg;
        unique case (state_reg)
            sitr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next = value_u[MW-1];
                    mag_next = value_u[MW-1] ? (~value_u + MW'(1)) : value_u;
                    nd_next  = '0;
                end
            end
            sitr_pkg::ST_LOAD:
            begin
                len_next  = load_len;
                ptr_next  = PW'(load_len - LW'(1));
                rem_next  = '0;
                topz_next = 1'b0;
            end
            sitr_pkg::ST_DIVIDE:
            begin
                // The quotient nibble replaces the dividend nibble in place.
                mag_next[{ptr_reg, 2'b00} +: NW] = q;
                rem_next = r;
                if (at_top)
                begin
                    topz_next = (q == '0);
                end
                if (pass_end)
                begin
                    // The remainder is the next digit, least significant
                    // first, so the top of the stack ends up most significant.
                    stack_next[0] = DW'(r);
                    for (int k = 1; k < SLOTS; k++)
                    begin
                        stack_next[k] = stack_reg[k - 1];
                    end
                    nd_next  = nd_reg + CW'(1);
                    len_next = len_new;
                    ptr_next = PW'(len_new - LW'(1));
                    rem_next = '0;
                end
                else
                begin
                    ptr_next = ptr_reg - PW'(1);
                end
            end
            sitr_pkg::ST_SIGN:
            begin
            end
            sitr_pkg::ST_EMIT:
            begin
                for (int k = 0; k < SLOTS - 1; k++)
                begin
                    stack_next[k] = stack_reg[k + 1];
                end
                nd_next = nd_reg - CW'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sitr_pkg::ST_IDLE;
            nd_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            nd_reg    <= nd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        len_reg   <= len_next;
        ptr_reg   <= ptr_next;
        rem_reg   <= rem_next;
        topz_reg  <= topz_next;
        stack_reg <= stack_next;
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        strobe    = 1'b0;
        character = syms[SIW'(stack_reg[0])];
        last_char = 1'b0;
        unique case (state_reg)
            sitr_pkg::ST_SIGN:
            begin
                strobe    = 1'b1;
                character = sitr_pkg::SYM_MINUS;
            end
            sitr_pkg::ST_EMIT:
            begin
                strobe    = 1'b1;
                last_char = (nd_reg == CW'(1));
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for signed_integer_to_radix_text_unit
// Drives signed values through the command port and symbol tables through the
// APB-style register port. It predicts the characters of each request, both
// the minus sign and the digits, and checks every strobed result against them.
// Directed cases cover the field extremes and each table rejection rule.
// Random phases then use random tables and values with random request gaps.
// ----------------------------------------------------------------------------
module tb;

    localparam int REG_STRIDE    = 8;
    localparam int REG_UNKNOWN   = 3;
    localparam int SETTLE_CYCLES = 200;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 320;

    // Byte k of this table is the symbol for digit k.
    localparam bit [127:0] HEX_TABLE = {"fedcba98", "76543210"};

    typedef struct {
        bit [7:0] ch;
        bit       last;
    } char_t;

    class text_book;
        char_t      pending_chars[$];
        bit [127:0] symbols;
        bit [4:0]   radix;
        int         errors;

        function new();
            symbols = '0;
            radix   = '0;
            errors  = 0;
        endfunction

        function void set_reg(int idx, bit [63:0] data);
            case (idx)
                sitr_pkg::REG_SYM_LO:   symbols[63:0]   = data;
                sitr_pkg::REG_SYM_HI:   symbols[127:64] = data;
                sitr_pkg::REG_BASE_LEN: radix           = data[4:0];
                default:      ;
            endcase
        endfunction

        function bit [63:0] reg_value(int idx);
            case (idx)
                sitr_pkg::REG_SYM_LO:   return symbols[63:0];
                sitr_pkg::REG_SYM_HI:   return symbols[127:64];
                default:      return {59'd0, radix};
            endcase
        endfunction

        function bit table_usable();
            int n;
            n = radix;
            if (n < 2 || n > sitr_pkg::MAX_BASE_DEF)
                return 1'b0;
            for (int i = 0; i < n; i++)
            begin
                if (symbols[8*i +: 8] == sitr_pkg::SYM_PLUS ||
                    symbols[8*i +: 8] == sitr_pkg::SYM_MINUS ||
                    symbols[8*i +: 8] == sitr_pkg::SYM_NUL)
                    return 1'b0;
                for (int j = i + 1; j < n; j++)
                begin
                    if (symbols[8*j +: 8] == symbols[8*i +: 8])
                        return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void note_request(bit [31:0] v);
            bit [32:0] mag;
            bit [3:0]  digits[$];
            char_t     c;
            if (!table_usable())
                return;
            // The magnitude takes 33 bits so that the most negative value fits.
            mag = v[31] ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
            do
            begin
                digits.push_front(4'(mag % radix));
                mag = mag / radix;
            end
            while (mag != 0);
            if (v[31])
            begin
                c.ch   = sitr_pkg::SYM_MINUS;
                c.last = 1'b0;
                pending_chars.push_back(c);
            end
            foreach (digits[i])
            begin
                c.ch   = symbols[8*digits[i] +: 8];
                c.last = (i == digits.size() - 1);
                pending_chars.push_back(c);
            end
        endfunction

        function void report(string msg);
            errors++;
            $display("MISMATCH: %s", msg);
        endfunction

        function void check_char(bit [7:0] ch, bit last);
            char_t e;
            if (pending_chars.size() == 0)
            begin
                report($sformatf("unexpected character 0x%02h last_char=%0b", ch, last));
                return;
            end
            e = pending_chars.pop_front();
            if (ch != e.ch)
                report($sformatf("character 0x%02h, expected 0x%02h", ch, e.ch));
            if (last != e.last)
                report($sformatf("last_char %0b, expected %0b", last, e.last));
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction

        function void flush_missing();
            char_t e;
            while (pending_chars.size() > 0)
            begin
                e = pending_chars.pop_front();
                report($sformatf("missing character 0x%02h last_char=%0b", e.ch, e.last));
            end
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [sitr_pkg::ADDR_W-1:0]   paddr;
    logic [sitr_pkg::DATA_W-1:0]   pwdata;
    logic [sitr_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          start;
    logic signed [31:0]            value;
    logic                          busy;
    logic                          strobe;
    logic [7:0]                    character;
    logic                          last_char;

    text_book book = new();
    int       cycles = 0;

    signed_integer_to_radix_text_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .start     (start),
        .value     (value),
        .busy      (busy),
        .strobe    (strobe),
        .character (character),
        .last_char (last_char)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe)
            book.check_char(character, last_char);
    end

    // All tasks below are entered and left at a falling edge.
    task automatic reg_write(input int idx, input bit [63:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = sitr_pkg::ADDR_W'(idx * REG_STRIDE);
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        forever
        begin
            @(posedge clk);
            if (pready)
                break;
        end
        book.set_reg(idx, data);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic reg_read(input int idx);
        logic [63:0] got;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = sitr_pkg::ADDR_W'(idx * REG_STRIDE);
        @(negedge clk);
        penable = 1'b1;
        forever
        begin
            @(posedge clk);
            if (pready)
                break;
        end
        got = prdata;
        if (got !== book.reg_value(idx))
            book.report($sformatf("register %0d reads 0x%016h, expected 0x%016h",
                                  idx, got, book.reg_value(idx)));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Holds requests off until every predicted character has arrived or DRAIN_LIMIT
    // runs out, then lets the given number of cycles pass for work that produces nothing.
    task automatic wait_drained(input int settle);
        int waited;
        start  = 1'b0;
        waited = 0;
        while (book.pending() > 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        book.flush_missing();
        repeat (settle) @(negedge clk);
    endtask

    task automatic set_table(input bit [127:0] tbl, input bit [63:0] len_word);
        wait_drained(SETTLE_CYCLES);
        reg_write(sitr_pkg::REG_SYM_LO, tbl[63:0]);
        reg_write(sitr_pkg::REG_SYM_HI, tbl[127:64]);
        reg_write(sitr_pkg::REG_BASE_LEN, len_word);
        reg_read(sitr_pkg::REG_SYM_LO);
        reg_read(sitr_pkg::REG_SYM_HI);
        reg_read(sitr_pkg::REG_BASE_LEN);
    endtask

    task automatic issue_request(input bit [31:0] v);
        start = 1'b1;
        value = v;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        book.note_request(v);
        @(negedge clk);
    endtask

    // Mode 0 keeps start high back to back, mode 1 leaves short gaps and
    // mode 2 mixes in the odd long one.
    task automatic request_gap(input int mode);
        int g;
        g = 0;
        if (mode == 2 && $urandom_range(0, 9) == 0)
            g = $urandom_range(20, 80);
        else if (mode != 0)
            g = $urandom_range(0, 3);
        if (g > 0)
        begin
            start = 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    function automatic bit [31:0] rand_value(input int n);
        bit [31:0] v;
        longint    p;
        int        e;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h0000_0000;
                    1:       v = 32'hFFFF_FFFF;
                    2:       v = 32'h0000_0001;
                    3:       v = 32'h7FFF_FFFF;
                    default: v = 32'h8000_0000;
                endcase
            end
            1, 2:
            begin
                v = $urandom_range(0, 2 * n * n);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            3:
            begin
                // Values near a power of the radix, where the digit count steps.
                p = 1;
                e = $urandom_range(1, 31);
                repeat (e)
                begin
                    if (p * n <= 64'sh8000_0000)
                        p = p * n;
                end
                v = 32'(p + $urandom_range(0, 2) - 1);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic random_phase(output int usable_items);
        bit [127:0] tbl;
        bit [63:0]  len_word;
        bit [255:0] taken;
        bit [7:0]   s;
        int         n, k, j, count, gap_mode;
        bit         broken;
        case ($urandom_range(0, 5))
            0:       n = 2;
            1:       n = sitr_pkg::MAX_BASE_DEF;
            default: n = $urandom_range(2, sitr_pkg::MAX_BASE_DEF);
        endcase
        // Slots beyond the radix keep random bytes, which must be ignored.
        tbl   = {$urandom, $urandom, $urandom, $urandom};
        taken = '0;
        for (k = 0; k < n; k++)
        begin
            do
                s = 8'($urandom_range(1, 255));
            while (s == sitr_pkg::SYM_PLUS || s == sitr_pkg::SYM_MINUS || taken[s]);
            taken[s]        = 1'b1;
            tbl[8*k +: 8]   = s;
        end
        len_word = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'd0;
        len_word[4:0] = 5'(n);
        broken = ($urandom_range(0, 4) == 0);
        if (broken)
        begin
            case ($urandom_range(0, 3))
                0: len_word[4:0] = 5'($urandom_range(0, 1));
                1: len_word[4:0] = 5'($urandom_range(sitr_pkg::MAX_BASE_DEF + 1, 31));
                2:
                begin
                    k = $urandom_range(0, n - 1);
                    case ($urandom_range(0, 2))
                        0:       tbl[8*k +: 8] = sitr_pkg::SYM_PLUS;
                        1:       tbl[8*k +: 8] = sitr_pkg::SYM_MINUS;
                        default: tbl[8*k +: 8] = sitr_pkg::SYM_NUL;
                    endcase
                end
                default:
                begin
                    k = $urandom_range(0, n - 1);
                    do
                        j = $urandom_range(0, n - 1);
                    while (j == k);
                    tbl[8*j +: 8] = tbl[8*k +: 8];
                end
            endcase
        end
        set_table(tbl, len_word);
        count    = broken ? 4 : $urandom_range(15, 30);
        gap_mode = $urandom_range(0, 2);
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2 && $urandom_range(0, 3) == 0)
                wait_drained(0);
            issue_request(rand_value(n));
            request_gap(gap_mode);
        end
        usable_items = book.table_usable() ? count : 0;
    endtask

    initial
    begin
        bit [127:0] tbl;
        int         done_items;
        int         phase_items;

        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        start   = 1'b0;
        value   = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // The table is empty after reset, so nothing may come out.
        issue_request(32'h0000_0000);
        issue_request(32'h8000_0000);

        // Radix too small, with a write to an unmapped register as well.
        set_table(HEX_TABLE, 64'd1);
        reg_write(REG_UNKNOWN, '1);
        reg_read(sitr_pkg::REG_SYM_LO);
        reg_read(sitr_pkg::REG_BASE_LEN);
        issue_request(32'd7);

        // Radix too large; the upper bits of the write are not part of it.
        set_table(HEX_TABLE, 64'hFFFF_FFFF_FFFF_FFF1);
        issue_request(32'd7);

        set_table(HEX_TABLE, 64'd10);
        reg_write(REG_UNKNOWN, 64'h5555_5555_5555_5555);
        reg_read(sitr_pkg::REG_SYM_HI);
        issue_request(32'd0);
        issue_request(32'hFFFF_FFFF);
        issue_request(32'h7FFF_FFFF);
        issue_request(32'h8000_0000);
        issue_request(32'd100);
        issue_request(-32'sd305);

        // Radix two gives the longest text.
        set_table(HEX_TABLE, 64'd2);
        issue_request(32'h8000_0000);
        issue_request(32'h7FFF_FFFF);

        set_table(HEX_TABLE, 64'd16);
        issue_request(32'h8000_0000);
        issue_request(32'hDEAD_BEEF);
        issue_request(32'd255);

        // Forbidden symbols inside the radix.
        tbl = HEX_TABLE;
        tbl[8*12 +: 8] = sitr_pkg::SYM_PLUS;
        set_table(tbl, 64'd16);
        issue_request(32'd1);
        tbl = HEX_TABLE;
        tbl[7:0] = sitr_pkg::SYM_MINUS;
        set_table(tbl, 64'd2);
        issue_request(32'd1);
        tbl = HEX_TABLE;
        tbl[8*5 +: 8] = sitr_pkg::SYM_NUL;
        set_table(tbl, 64'd8);
        issue_request(32'd1);

        // A zero byte past the radix is ignored.
        tbl = HEX_TABLE;
        tbl[8*7 +: 8] = sitr_pkg::SYM_NUL;
        set_table(tbl, 64'd5);
        issue_request(32'd12345);
        issue_request(-32'sd4);

        // Repeated symbols, across the two registers and at the top end.
        tbl = HEX_TABLE;
        tbl[8*11 +: 8] = tbl[8*3 +: 8];
        set_table(tbl, 64'd16);
        issue_request(32'd1);
        tbl = HEX_TABLE;
        tbl[8*15 +: 8] = tbl[8*14 +: 8];
        set_table(tbl, 64'd16);
        issue_request(32'd1);

        // A repeat that only involves a slot past the radix is harmless.
        tbl = HEX_TABLE;
        tbl[8*9 +: 8] = tbl[8*2 +: 8];
        set_table(tbl, 64'd9);
        issue_request(-32'sd99999);

        done_items = 0;
        while (done_items < RANDOM_ITEMS)
        begin
            random_phase(phase_items);
            done_items += phase_items;
        end

        wait_drained(SETTLE_CYCLES);
        if (book.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
